// File: design/scs1_pkg.sv
// Package for the scan-code set 1 to ASCII translator.
// Holds key codes, the tracked key state type and the keymap tables.
// No dependencies.
package scs1_pkg;

  // Key codes, table size and character constants
  localparam logic [7:0] KeyLshift  = 8'h2A;
  localparam logic [7:0] KeyRshift  = 8'h36;
  localparam logic [7:0] KeyCaps    = 8'h3A;
  localparam logic [7:0] TableSize  = 8'd58;
  localparam logic [6:0] CaseOffset = 7'd32;
  localparam logic [6:0] LowerA     = 7'h61;
  localparam logic [6:0] LowerZ     = 7'h7A;

  // Tracked keyboard state
  typedef struct packed {
    logic       shift_held;
    logic       caps_lock_active;
    logic       caps_key_down;
    logic [7:0] previous_key;
  } state_t;

  // Translation of one code
  typedef struct packed {
    logic       emit;
    logic [6:0] ascii_char;
  } xlate_t;

  // Unshifted keymap, codes 0 to 57
  function automatic logic [6:0] plain_char(input logic [5:0] idx);
    logic [6:0] ch;
    case (idx)
      6'd1:    ch = 7'h1B;
      6'd2:    ch = 7'h31;
      6'd3:    ch = 7'h32;
      6'd4:    ch = 7'h33;
      6'd5:    ch = 7'h34;
      6'd6:    ch = 7'h35;
      6'd7:    ch = 7'h36;
      6'd8:    ch = 7'h37;
      6'd9:    ch = 7'h38;
      6'd10:   ch = 7'h39;
      6'd11:   ch = 7'h30;
      6'd12:   ch = 7'h2D;
      6'd13:   ch = 7'h3D;
      6'd14:   ch = 7'h08;
      6'd15:   ch = 7'h09;
      6'd16:   ch = 7'h71;
      6'd17:   ch = 7'h77;
      6'd18:   ch = 7'h65;
      6'd19:   ch = 7'h72;
      6'd20:   ch = 7'h74;
      6'd21:   ch = 7'h79;
      6'd22:   ch = 7'h75;
      6'd23:   ch = 7'h69;
      6'd24:   ch = 7'h6F;
      6'd25:   ch = 7'h70;
      6'd26:   ch = 7'h5B;
      6'd27:   ch = 7'h5D;
      6'd28:   ch = 7'h0A;
      6'd30:   ch = 7'h61;
      6'd31:   ch = 7'h73;
      6'd32:   ch = 7'h64;
      6'd33:   ch = 7'h66;
      6'd34:   ch = 7'h67;
      6'd35:   ch = 7'h68;
      6'd36:   ch = 7'h6A;
      6'd37:   ch = 7'h6B;
      6'd38:   ch = 7'h6C;
      6'd39:   ch = 7'h3B;
      6'd40:   ch = 7'h27;
      6'd41:   ch = 7'h60;
      6'd43:   ch = 7'h5C;
      6'd44:   ch = 7'h7A;
      6'd45:   ch = 7'h78;
      6'd46:   ch = 7'h63;
      6'd47:   ch = 7'h76;
      6'd48:   ch = 7'h62;
      6'd49:   ch = 7'h6E;
      6'd50:   ch = 7'h6D;
      6'd51:   ch = 7'h2C;
      6'd52:   ch = 7'h2E;
      6'd53:   ch = 7'h2F;
      6'd55:   ch = 7'h2A;
      6'd57:   ch = 7'h20;
      default: ch = 7'h00;
    endcase
    return ch;
  endfunction

  // Shifted keymap for non-letter keys; entries equal to the unshifted
  // character, and letters (handled by case folding), read as zero
  function automatic logic [6:0] shift_char(input logic [5:0] idx);
    logic [6:0] ch;
    case (idx)
      6'd2:    ch = 7'h21;
      6'd3:    ch = 7'h40;
      6'd4:    ch = 7'h23;
      6'd5:    ch = 7'h24;
      6'd6:    ch = 7'h25;
      6'd7:    ch = 7'h5E;
      6'd8:    ch = 7'h26;
      6'd9:    ch = 7'h2A;
      6'd10:   ch = 7'h28;
      6'd11:   ch = 7'h29;
      6'd12:   ch = 7'h5F;
      6'd13:   ch = 7'h2B;
      6'd26:   ch = 7'h7B;
      6'd27:   ch = 7'h7D;
      6'd39:   ch = 7'h3A;
      6'd40:   ch = 7'h22;
      6'd41:   ch = 7'h7E;
      6'd43:   ch = 7'h7C;
      6'd51:   ch = 7'h3C;
      6'd52:   ch = 7'h3E;
      6'd53:   ch = 7'h3F;
      default: ch = 7'h00;
    endcase
    return ch;
  endfunction

endpackage

// File: design/scs1_xlate.sv
// Combinational translation of one set-1 scan code.
// Computes the next key state and the optional ASCII result.
// Depends on scs1_pkg.
module scs1_xlate (
  input  logic [7:0]       code_i,
  input  scs1_pkg::state_t state_i,
  output scs1_pkg::state_t state_o,
  output scs1_pkg::xlate_t result_o
);

  logic       release_flag;
  logic [6:0] key;
  logic [6:0] plain;
  logic [6:0] shifted;
  logic       is_letter;

  assign release_flag = code_i[7];
  assign key          = code_i[6:0];

  // Look up both keymaps
  assign plain     = scs1_pkg::plain_char(code_i[5:0]);
  assign shifted   = scs1_pkg::shift_char(code_i[5:0]);
  assign is_letter = (plain >= scs1_pkg::LowerA) && (plain <= scs1_pkg::LowerZ);

  // Update key state and decide whether a character goes out
  always_comb begin
    state_o       = state_i;
    result_o.emit = 1'b0;
    if (release_flag) begin
      if (({1'b0, key} == scs1_pkg::KeyLshift) || ({1'b0, key} == scs1_pkg::KeyRshift)) begin
        state_o.shift_held = 1'b0;
      end else if ({1'b0, key} == scs1_pkg::KeyCaps) begin
        state_o.caps_key_down = 1'b0;
      end
      if ({1'b0, key} == state_i.previous_key) begin
        state_o.previous_key = 8'd0;
      end
    end else if ((code_i == scs1_pkg::KeyLshift) || (code_i == scs1_pkg::KeyRshift)) begin
      state_o.shift_held = 1'b1;
    end else if (code_i == scs1_pkg::KeyCaps) begin
      if (!state_i.caps_key_down) begin
        state_o.caps_lock_active = ~state_i.caps_lock_active;
        state_o.caps_key_down    = 1'b1;
      end
    end else if (code_i != state_i.previous_key) begin
      state_o.previous_key = code_i;
      result_o.emit        = (code_i < scs1_pkg::TableSize);
    end
  end

  // Pick the character: fold letter case, else use the shifted entry while shift is held, else the plain one
  always_comb begin
    if (is_letter && (state_i.shift_held ^ state_i.caps_lock_active)) begin
      result_o.ascii_char = plain - scs1_pkg::CaseOffset;
    end else if (!is_letter && state_i.shift_held && (shifted != 7'd0)) begin
      result_o.ascii_char = shifted;
    end else begin
      result_o.ascii_char = plain;
    end
  end

endmodule

// File: design/scancode_set1_to_ascii_core.sv
// Scan-code set 1 to ASCII translator, top level.
// The code enters the input register at the transfer; its translation enters the
// result register when the code advances, which waits while the result register
// holds a stalled character. One code per cycle while no code waits on a stall.
// Codes that give no character retire without using the result register.
// Reset clears the key state (shift, caps lock, caps key, last key) and
// both valid flags; depends on scs1_pkg and scs1_xlate.
module scancode_set1_to_ascii_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] scan_code_i,
  input  logic       scan_code_valid_i,
  output logic       scan_code_ready_o,
  output logic [6:0] ascii_char_o,
  output logic       ascii_char_valid_o,
  input  logic       ascii_char_ready_i
);

  logic             in_valid_q, in_valid_d;
  logic [7:0]       in_code_q;
  scs1_pkg::state_t state_q, state_d;
  scs1_pkg::xlate_t xlate;
  logic             out_valid_q, out_valid_d;
  logic [6:0]       out_char_q;
  logic             out_free;
  logic             advance;
  logic             in_xfer;

  scs1_xlate u_xlate (
    .code_i  (in_code_q),
    .state_i (state_q),
    .state_o (state_d),
    .result_o(xlate)
  );

  // Advance the held code when its result has room or it gives none
  assign out_free          = !out_valid_q || ascii_char_ready_i;
  assign advance           = in_valid_q && (out_free || !xlate.emit);
  assign scan_code_ready_o = !in_valid_q || advance;
  assign in_xfer           = scan_code_valid_i && scan_code_ready_o;

  assign in_valid_d  = in_xfer || (in_valid_q && !advance);
  assign out_valid_d = (advance && xlate.emit) || (out_valid_q && !ascii_char_ready_i);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_code_q <= scan_code_i;
    end
    if (advance && xlate.emit) begin
      out_char_q <= xlate.ascii_char;
    end
  end

  assign ascii_char_o       = out_char_q;
  assign ascii_char_valid_o = out_valid_q;

endmodule

// File: design/scs1_checker.sv
// Port-level checks for the scan-code translator.
// Bound to scancode_set1_to_ascii_core; uses only its ports.
module scs1_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic [7:0] scan_code_i,
  input logic       scan_code_valid_i,
  input logic       scan_code_ready_o,
  input logic [6:0] ascii_char_o,
  input logic       ascii_char_valid_o,
  input logic       ascii_char_ready_i
);

  // Hold result valid until transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ascii_char_valid_o && !ascii_char_ready_i |=> ascii_char_valid_o)
    else $error("result valid dropped before transfer");

  // Hold result payload while stalled
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ascii_char_valid_o && !ascii_char_ready_i |=> $stable(ascii_char_o))
    else $error("result payload changed while stalled");

  // Back-pressure on input only when the result side is stalled
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !scan_code_ready_o |-> ascii_char_valid_o && !ascii_char_ready_i)
    else $error("input stalled without a stalled result");

  // No result straight out of reset
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !ascii_char_valid_o)
    else $error("result valid right after reset");

endmodule

bind scancode_set1_to_ascii_core scs1_checker u_scs1_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .scan_code_i       (scan_code_i),
  .scan_code_valid_i (scan_code_valid_i),
  .scan_code_ready_o (scan_code_ready_o),
  .ascii_char_o      (ascii_char_o),
  .ascii_char_valid_o(ascii_char_valid_o),
  .ascii_char_ready_i(ascii_char_ready_i)
);
